FILE: rtl/core/bmli_pkg.sv
package bmli_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int MV_W       = 15;
  localparam int CHG_MV_W   = 16;
  localparam int PERC_W     = 7;
  localparam int CNT_W      = 17;
  localparam int PT_W       = 10;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [PT_W-1:0] PATTERN_PERIOD = 10'd1000;
  localparam logic [PT_W-1:0] HALF_PERIOD    = 10'd500;
  localparam logic [PT_W-1:0] IDLE_FLASH_LEN = 10'd4;

  // millivolts = floor(sum * k / 10000) = (sum * ceil(k * 2^31 / 10000)) >> 31
  localparam int              RECIP_W     = 34;
  localparam int              SCALE_SHIFT = 31;
  localparam logic [RECIP_W-1:0] BAT_RECIP = 34'd6286114135;
  localparam logic [RECIP_W-1:0] CHG_RECIP = 34'd8639111968;
  localparam logic [MV_W-1:0]     BAT_MV_MAX = 15'd32767;
  localparam logic [CHG_MV_W-1:0] CHG_MV_MAX = 16'd65535;

  // percent = (mv - 16000) / 50, saturated at 127 from a difference of 6350
  localparam logic [MV_W-1:0]   PERC_BASE_MV  = 15'd16000;
  localparam logic [MV_W-1:0]   PERC_SAT_DIFF = 15'd6350;
  localparam int                PERC_DIFF_W   = 13;
  localparam logic [15:0]       PERC_RECIP    = 16'd41944;
  localparam int                PERC_SHIFT    = 21;
  localparam logic [PERC_W-1:0] PERC_MAX      = 7'd127;

  localparam logic [2:0] REG_EMERG_LEVEL   = 3'd0;
  localparam logic [2:0] REG_CHARGER_LEVEL = 3'd1;
  localparam logic [2:0] REG_WARN_PERCENT  = 3'd2;
  localparam logic [2:0] REG_SHUT_PERCENT  = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE      = 3'd4;
  localparam logic [2:0] REG_REREACTION    = 3'd5;
  localparam logic [2:0] REG_MOTION_EN     = 3'd6;

  typedef struct packed {
    logic [SAMPLE_W-1:0] bat_sample_a;
    logic [SAMPLE_W-1:0] bat_sample_b;
    logic [SAMPLE_W-1:0] chg_sample_a;
    logic [SAMPLE_W-1:0] chg_sample_b;
    logic                blink_left_req;
    logic                blink_right_req;
    logic                forward_req;
  } in_item_t;

  typedef struct packed {
    logic              left_light;
    logic              right_light;
    logic              front_light;
    logic              in_charger;
    logic              emergency_active;
    logic              emergency_action;
    logic              kill_power;
    logic              low_bat_blink;
    logic [MV_W-1:0]   battery_mv;
    logic [PERC_W-1:0] battery_percent;
  } out_item_t;

  typedef struct packed {
    logic [MV_W-1:0]     emerg_level_mv;
    logic [CHG_MV_W-1:0] charger_level_mv;
    logic [PERC_W-1:0]   warn_percent;
    logic [PERC_W-1:0]   shutdown_percent;
    logic [15:0]         debounce_ticks;
    logic [15:0]         rereaction_ticks;
    logic                motion_led_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    emerg_level_mv:    15'd21500,
    charger_level_mv:  16'd20000,
    warn_percent:      7'd30,
    shutdown_percent:  7'd5,
    debounce_ticks:    16'd500,
    rereaction_ticks:  16'd30000,
    motion_led_enable: 1'b1
  };

  // classified tick, front to back
  typedef struct packed {
    logic [MV_W-1:0]   battery_mv;
    logic [PERC_W-1:0] battery_percent;
    logic              over_voltage;
    logic              charger_high;
    logic              warn_low;
    logic              shut_low;
    logic              left_req;
    logic              right_req;
    logic              forward_req;
  } tick_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c == '1) ? c : c + 1'b1;
    return r;
  endfunction

  // emergency blink: switching points every 100 ticks, on at even hundreds
  function automatic logic [1:0] fast_blink(input logic [PT_W-1:0] pt);
    logic [1:0] r;
    r = 2'b00;
    for (int k = 0; k < 5; k++) begin
      if (pt == PT_W'(200 * k)) r = 2'b11;
      if (pt == PT_W'(200 * k + 100)) r = 2'b10;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/bmli_fifo.sv
module bmli_fifo #(
  parameter type item_t = logic,
  parameter int  Depth  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/bmli_front.sv
module bmli_front #(
  parameter int AdcBits = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bmli_pkg::in_item_t in_item_i,
  output logic              full_o,
  input  bmli_pkg::cfg_t    cfg_i,
  output logic              tick_push_o,
  output bmli_pkg::tick_t   tick_o,
  input  logic              tick_full_i
);

  import bmli_pkg::*;

  localparam int SampW = (AdcBits < SAMPLE_W) ? AdcBits : SAMPLE_W;
  localparam int SumW  = SampW + 1;
  localparam int ProdW = SumW + RECIP_W;
  localparam int QW    = ProdW - SCALE_SHIFT;
  localparam int PpW   = PERC_DIFF_W + 16;

  logic [SumW-1:0]     bat_sum, chg_sum;
  logic [ProdW-1:0]    bat_prod, chg_prod;
  logic [QW-1:0]       bat_q, chg_q;
  logic [MV_W-1:0]     bat_mv_d, bat_mv_q;
  logic [CHG_MV_W-1:0] chg_mv_d, chg_mv_q;
  logic [2:0]          req_q;
  logic                s1_valid_q, s1_load;
  logic [MV_W-1:0]     diff;
  logic [PpW-1:0]      perc_prod;
  logic [PERC_W-1:0]   perc;

  // stage 1: sample sums scaled to millivolts
  assign bat_sum  = SumW'(in_item_i.bat_sample_a[SampW-1:0])
                  + SumW'(in_item_i.bat_sample_b[SampW-1:0]);
  assign chg_sum  = SumW'(in_item_i.chg_sample_a[SampW-1:0])
                  + SumW'(in_item_i.chg_sample_b[SampW-1:0]);
  assign bat_prod = ProdW'(bat_sum) * ProdW'(BAT_RECIP);
  assign chg_prod = ProdW'(chg_sum) * ProdW'(CHG_RECIP);
  assign bat_q    = bat_prod[ProdW-1:SCALE_SHIFT];
  assign chg_q    = chg_prod[ProdW-1:SCALE_SHIFT];
  assign bat_mv_d = (32'(bat_q) > 32'(BAT_MV_MAX)) ? BAT_MV_MAX : MV_W'(bat_q);
  assign chg_mv_d = (32'(chg_q) > 32'(CHG_MV_MAX)) ? CHG_MV_MAX : CHG_MV_W'(chg_q);

  assign s1_load     = !s1_valid_q || !tick_full_i;
  assign full_o      = !s1_load;
  assign tick_push_o = s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && push_i) begin
      bat_mv_q <= bat_mv_d;
      chg_mv_q <= chg_mv_d;
      req_q    <= {in_item_i.forward_req, in_item_i.blink_right_req,
                   in_item_i.blink_left_req};
    end
  end

  // stage 2: percentage and threshold classification
  assign diff      = bat_mv_q - PERC_BASE_MV;
  assign perc_prod = PpW'(diff[PERC_DIFF_W-1:0]) * PpW'(PERC_RECIP);

  always_comb begin
    if (bat_mv_q <= PERC_BASE_MV) begin
      perc = '0;
    end else if (diff >= PERC_SAT_DIFF) begin
      perc = PERC_MAX;
    end else begin
      perc = perc_prod[PERC_SHIFT+PERC_W-1:PERC_SHIFT];
    end
  end

  always_comb begin
    tick_o.battery_mv      = bat_mv_q;
    tick_o.battery_percent = perc;
    tick_o.over_voltage    = bat_mv_q > cfg_i.emerg_level_mv;
    tick_o.charger_high    = chg_mv_q > cfg_i.charger_level_mv;
    tick_o.warn_low        = perc < cfg_i.warn_percent;
    tick_o.shut_low        = perc < cfg_i.shutdown_percent;
    tick_o.left_req        = req_q[0];
    tick_o.right_req       = req_q[1];
    tick_o.forward_req     = req_q[2];
  end

endmodule

FILE: rtl/core/bmli_back.sv
module bmli_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_empty_i,
  input  bmli_pkg::tick_t     tick_i,
  output logic                tick_pop_o,
  input  bmli_pkg::cfg_t      cfg_i,
  input  logic                out_full_i,
  output logic                out_push_o,
  output bmli_pkg::out_item_t out_item_o
);

  import bmli_pkg::*;

  logic [PT_W-1:0]  pt_q, pt_d, pt_inc;
  logic [CNT_W-1:0] emerg_cnt_q, emerg_cnt_d;
  logic [CNT_W-1:0] warn_cnt_q, warn_cnt_d;
  logic [CNT_W-1:0] shut_cnt_q, shut_cnt_d;
  logic [CNT_W-1:0] rr_cnt_q, rr_cnt_d;
  logic             emerg_latch_q, emerg_latch_d;
  logic             low_bat_q, low_bat_d;
  logic [2:0]       lights_q, lights_d;
  logic             go, action, kill, in_chg, first_half;
  logic [1:0]       blink;

  assign go         = !tick_empty_i && !out_full_i;
  assign tick_pop_o = go;
  assign out_push_o = go;
  assign pt_inc     = (pt_q >= PATTERN_PERIOD - 1'b1) ? '0 : pt_q + 1'b1;
  assign blink      = fast_blink(pt_inc);
  assign first_half = pt_inc < HALF_PERIOD;

  always_comb begin
    pt_d          = pt_q;
    emerg_cnt_d   = emerg_cnt_q;
    warn_cnt_d    = warn_cnt_q;
    shut_cnt_d    = shut_cnt_q;
    rr_cnt_d      = rr_cnt_q;
    emerg_latch_d = emerg_latch_q;
    low_bat_d     = low_bat_q;
    lights_d      = lights_q;
    action        = 1'b0;
    kill          = 1'b0;
    in_chg        = tick_i.charger_high;
    if (go) begin
      pt_d = pt_inc;
      if (emerg_latch_q) begin
        lights_d[2] = 1'b0;
        if (blink[1]) begin
          lights_d[1:0] = {2{blink[0]}};
        end
        if (tick_i.over_voltage) begin
          rr_cnt_d = sat_inc(rr_cnt_q);
          if (rr_cnt_d > CNT_W'(cfg_i.rereaction_ticks)) begin
            rr_cnt_d = '0;
            action   = 1'b1;
            in_chg   = 1'b0;
          end
        end
      end else begin
        if (tick_i.over_voltage) begin
          emerg_cnt_d = sat_inc(emerg_cnt_q);
          if (emerg_cnt_d > CNT_W'(cfg_i.debounce_ticks)) begin
            emerg_latch_d = 1'b1;
            action        = 1'b1;
          end
        end else begin
          emerg_cnt_d = '0;
        end

        if (tick_i.warn_low) begin
          warn_cnt_d = sat_inc(warn_cnt_q);
          if (warn_cnt_d > CNT_W'(cfg_i.debounce_ticks)) begin
            low_bat_d = 1'b1;
          end
        end else begin
          warn_cnt_d = '0;
          low_bat_d  = 1'b0;
        end

        if (tick_i.shut_low) begin
          shut_cnt_d = sat_inc(shut_cnt_q);
          kill       = shut_cnt_d > CNT_W'(cfg_i.debounce_ticks);
        end else begin
          shut_cnt_d = '0;
        end

        if (low_bat_d) begin
          // triple blink at the start of each period
          lights_d[2] = 1'b0;
          if (pt_inc == 10'd0 || pt_inc == 10'd200 || pt_inc == 10'd400) begin
            lights_d[1:0] = 2'b11;
          end else if (pt_inc == 10'd50 || pt_inc == 10'd250 || pt_inc == 10'd450) begin
            lights_d[1:0] = 2'b00;
          end
        end else if (cfg_i.motion_led_enable) begin
          if (!tick_i.left_req && !tick_i.right_req && !tick_i.forward_req) begin
            lights_d = (pt_inc < IDLE_FLASH_LEN) ? 3'b111 : 3'b000;
          end else begin
            lights_d = {tick_i.forward_req, tick_i.right_req && first_half,
                        tick_i.left_req && first_half};
          end
        end else begin
          lights_d = '0;
        end
      end
    end
  end

  always_comb begin
    out_item_o.left_light       = lights_d[0];
    out_item_o.right_light      = lights_d[1];
    out_item_o.front_light      = lights_d[2];
    out_item_o.in_charger       = in_chg;
    out_item_o.emergency_active = emerg_latch_d;
    out_item_o.emergency_action = action;
    out_item_o.kill_power       = kill;
    out_item_o.low_bat_blink    = low_bat_d && !emerg_latch_d;
    out_item_o.battery_mv       = tick_i.battery_mv;
    out_item_o.battery_percent  = tick_i.battery_percent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q          <= '0;
      emerg_cnt_q   <= '0;
      warn_cnt_q    <= '0;
      shut_cnt_q    <= '0;
      rr_cnt_q      <= '0;
      emerg_latch_q <= 1'b0;
      low_bat_q     <= 1'b0;
      lights_q      <= '0;
    end else begin
      pt_q          <= pt_d;
      emerg_cnt_q   <= emerg_cnt_d;
      warn_cnt_q    <= warn_cnt_d;
      shut_cnt_q    <= shut_cnt_d;
      rr_cnt_q      <= rr_cnt_d;
      emerg_latch_q <= emerg_latch_d;
      low_bat_q     <= low_bat_d;
      lights_q      <= lights_d;
    end
  end

`ifndef SYNTHESIS
  a_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emerg_latch_q |=> emerg_latch_q)
    else $error("emergency latch cleared without reset");

  a_action_needs_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o && out_item_o.emergency_action |-> tick_i.over_voltage)
    else $error("emergency action without over-voltage");

  a_no_kill_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o && emerg_latch_q |-> !out_item_o.kill_power && !out_item_o.front_light)
    else $error("kill or front light while emergency latched");

  a_rereaction_drops_charger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o && emerg_latch_q && out_item_o.emergency_action |-> !out_item_o.in_charger)
    else $error("charger flag set on rereaction tick");
`endif

endmodule

FILE: rtl/core/battery_monitor_led_indicator_top.sv
// channel  | direction | handshake           | payload
// request  | in        | push / full         | in_item_i   (bmli_pkg::in_item_t)
// result   | out       | empty / pop         | out_item_o  (bmli_pkg::out_item_t)
// config   | in / out  | psel, penable, ...  | paddr, pwdata, prdata
//
// one request per cycle sustained while the result side drains; a result passes through
// the scaling register, the classify queue and the back end update into the result queue
// the three constant multiplies sit in the front module, counters and lights in the back
// reset clears the counters, latch, lights and both queues; no clearing pass
// a stalled result side fills the result queue, then the classify queue, then full rises
module battery_monitor_led_indicator_top #(
  parameter int ADC_BITS    = 12,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  bmli_pkg::in_item_t            in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output bmli_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmli_pkg::ADDR_W-1:0]   paddr,
  input  logic [bmli_pkg::DATA_W-1:0]   pwdata,
  output logic [bmli_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  import bmli_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_we;
  logic [2:0] reg_idx;
  logic       tick_push, tick_full, tick_empty, tick_pop;
  tick_t      tick_in, tick_out;
  logic       out_push, out_full;
  out_item_t  out_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_EMERG_LEVEL:   cfg_q.emerg_level_mv    <= pwdata[MV_W-1:0];
        REG_CHARGER_LEVEL: cfg_q.charger_level_mv  <= pwdata[CHG_MV_W-1:0];
        REG_WARN_PERCENT:  cfg_q.warn_percent      <= pwdata[PERC_W-1:0];
        REG_SHUT_PERCENT:  cfg_q.shutdown_percent  <= pwdata[PERC_W-1:0];
        REG_DEBOUNCE:      cfg_q.debounce_ticks    <= pwdata[15:0];
        REG_REREACTION:    cfg_q.rereaction_ticks  <= pwdata[15:0];
        REG_MOTION_EN:     cfg_q.motion_led_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EMERG_LEVEL:   prdata = DATA_W'(cfg_q.emerg_level_mv);
      REG_CHARGER_LEVEL: prdata = DATA_W'(cfg_q.charger_level_mv);
      REG_WARN_PERCENT:  prdata = DATA_W'(cfg_q.warn_percent);
      REG_SHUT_PERCENT:  prdata = DATA_W'(cfg_q.shutdown_percent);
      REG_DEBOUNCE:      prdata = DATA_W'(cfg_q.debounce_ticks);
      REG_REREACTION:    prdata = DATA_W'(cfg_q.rereaction_ticks);
      REG_MOTION_EN:     prdata = DATA_W'(cfg_q.motion_led_enable);
      default:           prdata = '0;
    endcase
  end

  bmli_front #(
    .AdcBits(ADC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .full_o     (full),
    .cfg_i      (cfg_q),
    .tick_push_o(tick_push),
    .tick_o     (tick_in),
    .tick_full_i(tick_full)
  );

  bmli_fifo #(
    .item_t(tick_t),
    .Depth (QUEUE_DEPTH)
  ) u_tick_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (tick_push),
    .data_i (tick_in),
    .full_o (tick_full),
    .pop_i  (tick_pop),
    .data_o (tick_out),
    .empty_o(tick_empty)
  );

  bmli_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_empty_i(tick_empty),
    .tick_i      (tick_out),
    .tick_pop_o  (tick_pop),
    .cfg_i       (cfg_q),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_item_o  (out_item)
  );

  bmli_fifo #(
    .item_t(out_item_t),
    .Depth (QUEUE_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_item),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_item_o),
    .empty_o(empty)
  );

endmodule

FILE: test/battery_monitor_led_indicator_top_test.sv
module battery_monitor_led_indicator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bmli_pkg::*;

  localparam int          LIMIT_CYCLES = 200000;
  localparam int          MAX_WAIT     = 13;
  localparam logic [2:0]  REG_UNMAPPED = 3'd7;

  // battery sample-sum bands, chosen against the default warn, shutdown and emergency levels
  typedef enum logic [2:0] {
    BAND_ZERO, BAND_EMPTY, BAND_LOW, BAND_MID, BAND_HIGH, BAND_ANY
  } band_e;

  typedef enum logic [1:0] {MIX_LOW, MIX_EVEN, MIX_OVER} mix_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push;
  logic                full;
  in_item_t            in_item;
  logic                empty;
  logic                pop;
  out_item_t           out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predicted state of the monitor
  cfg_t                cfg_shadow;
  logic [PT_W-1:0]     pattern_phase;
  logic [CNT_W-1:0]    over_run;
  logic [CNT_W-1:0]    warn_run;
  logic [CNT_W-1:0]    shut_run;
  logic [CNT_W-1:0]    repeat_run;
  logic                emerg_latched;
  logic                low_warn;
  logic [2:0]          lamps;

  out_item_t           awaited_reports[$];
  int                  mismatches = 0;
  int                  cycle_count = 0;
  bit                  send_eager = 1'b0;
  bit                  drain_eager = 1'b0;
  int unsigned         drain_hold_cycles = 0;

  battery_monitor_led_indicator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(input bit eager);
    return eager ? 0 : $urandom_range(MAX_WAIT, 0);
  endfunction

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic in_item_t make_item(input logic [SAMPLE_W-1:0] ba, bb, ca, cb,
                                         input logic [2:0] reqs);
    in_item_t it;
    it.bat_sample_a = ba;
    it.bat_sample_b = bb;
    it.chg_sample_a = ca;
    it.chg_sample_b = cb;
    {it.blink_left_req, it.blink_right_req, it.forward_req} = reqs;
    return it;
  endfunction

  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_EMERG_LEVEL:   return 32'(cfg_shadow.emerg_level_mv);
      REG_CHARGER_LEVEL: return 32'(cfg_shadow.charger_level_mv);
      REG_WARN_PERCENT:  return 32'(cfg_shadow.warn_percent);
      REG_SHUT_PERCENT:  return 32'(cfg_shadow.shutdown_percent);
      REG_DEBOUNCE:      return 32'(cfg_shadow.debounce_ticks);
      REG_REREACTION:    return 32'(cfg_shadow.rereaction_ticks);
      REG_MOTION_EN:     return 32'(cfg_shadow.motion_led_enable);
      default:           return '0;
    endcase
  endfunction

  // one tick of the monitor: scaling, debounce counters, emergency and light patterns
  task automatic predict_report(input in_item_t it, output out_item_t rep);
    logic [31:0] bat_mv;
    logic [31:0] chg_mv;
    logic [31:0] perc;
    logic        in_chg;
    logic        over;
    logic        action;
    logic        kill;
    logic        first_half;
    bat_mv = ((32'(it.bat_sample_a) + 32'(it.bat_sample_b)) * 32'd29272) / 32'd10000;
    if (bat_mv > 32'd32767) bat_mv = 32'd32767;
    chg_mv = ((32'(it.chg_sample_a) + 32'(it.chg_sample_b)) * 32'd40229) / 32'd10000;
    if (chg_mv > 32'd65535) chg_mv = 32'd65535;
    perc = '0;
    if (bat_mv > 32'd16000) begin
      perc = (32'd100 * (bat_mv - 32'd16000)) / 32'd5000;
      if (perc > 32'd127) perc = 32'd127;
    end
    pattern_phase = (pattern_phase == PATTERN_PERIOD - 1'b1) ? '0 : pattern_phase + 1'b1;
    in_chg = chg_mv > 32'(cfg_shadow.charger_level_mv);
    over = bat_mv > 32'(cfg_shadow.emerg_level_mv);
    action = 1'b0;
    kill = 1'b0;
    if (emerg_latched) begin
      lamps[2] = 1'b0;
      if (pattern_phase % 100 == 0) begin
        lamps[1:0] = ((pattern_phase / 100) % 2 == 0) ? 2'b11 : 2'b00;
      end
      if (over) begin
        repeat_run = count_up(repeat_run);
        if (repeat_run > CNT_W'(cfg_shadow.rereaction_ticks)) begin
          repeat_run = '0;
          action = 1'b1;
          in_chg = 1'b0;
        end
      end
    end else begin
      if (over) begin
        over_run = count_up(over_run);
        if (over_run > CNT_W'(cfg_shadow.debounce_ticks)) begin
          emerg_latched = 1'b1;
          action = 1'b1;
        end
      end else begin
        over_run = '0;
      end
      if (perc < 32'(cfg_shadow.warn_percent)) begin
        warn_run = count_up(warn_run);
        if (warn_run > CNT_W'(cfg_shadow.debounce_ticks)) low_warn = 1'b1;
      end else begin
        warn_run = '0;
        low_warn = 1'b0;
      end
      if (perc < 32'(cfg_shadow.shutdown_percent)) begin
        shut_run = count_up(shut_run);
        if (shut_run > CNT_W'(cfg_shadow.debounce_ticks)) kill = 1'b1;
      end else begin
        shut_run = '0;
      end
      if (low_warn) begin
        // triple blink: on at 0, 200, 400 and off 50 ticks later
        lamps[2] = 1'b0;
        if (pattern_phase == 0 || pattern_phase == 200 || pattern_phase == 400) begin
          lamps[1:0] = 2'b11;
        end else if (pattern_phase == 50 || pattern_phase == 250 || pattern_phase == 450) begin
          lamps[1:0] = 2'b00;
        end
      end else if (cfg_shadow.motion_led_enable) begin
        first_half = pattern_phase < HALF_PERIOD;
        if (!it.blink_left_req && !it.blink_right_req && !it.forward_req) begin
          lamps = (pattern_phase < IDLE_FLASH_LEN) ? 3'b111 : 3'b000;
        end else begin
          lamps = {it.forward_req, it.blink_right_req && first_half,
                   it.blink_left_req && first_half};
        end
      end else begin
        lamps = 3'b000;
      end
    end
    rep.left_light       = lamps[0];
    rep.right_light      = lamps[1];
    rep.front_light      = lamps[2];
    rep.in_charger       = in_chg;
    rep.emergency_active = emerg_latched;
    rep.emergency_action = action;
    rep.kill_power       = kill;
    rep.low_bat_blink    = emerg_latched ? 1'b0 : low_warn;
    rep.battery_mv       = bat_mv[MV_W-1:0];
    rep.battery_percent  = perc[PERC_W-1:0];
  endtask

  always @(posedge clk_i) begin : report_check
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (awaited_reports.size() == 0) begin
        $error("result arrived with no request waiting");
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("left_light", want.left_light, out_item.left_light);
        check_field("right_light", want.right_light, out_item.right_light);
        check_field("front_light", want.front_light, out_item.front_light);
        check_field("in_charger", want.in_charger, out_item.in_charger);
        check_field("emergency_active", want.emergency_active, out_item.emergency_active);
        check_field("emergency_action", want.emergency_action, out_item.emergency_action);
        check_field("kill_power", want.kill_power, out_item.kill_power);
        check_field("low_bat_blink", want.low_bat_blink, out_item.low_bat_blink);
        check_field("battery_mv", want.battery_mv, out_item.battery_mv);
        check_field("battery_percent", want.battery_percent, out_item.battery_percent);
      end
    end
  end

  initial begin : result_drain
    int unsigned hold;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      hold = (drain_hold_cycles != 0) ? drain_hold_cycles : draw_wait(drain_eager);
      drain_hold_cycles = 0;
      if (hold != 0) begin
        pop <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      @(negedge clk_i);
    end
  end

  task automatic send_tick(input in_item_t it);
    int unsigned gap;
    out_item_t   want;
    gap = draw_wait(send_eager);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    predict_report(it, want);
    awaited_reports.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic send_band(input band_e band, input int count);
    int unsigned lo;
    int unsigned hi;
    int unsigned sum;
    int unsigned a;
    logic [SAMPLE_W-1:0] sa;
    logic [SAMPLE_W-1:0] sb;
    for (int n = 0; n < count; n++) begin
      case (band)
        BAND_ZERO:  begin lo = 0;    hi = 0;    end
        BAND_EMPTY: begin lo = 0;    hi = 5551; end
        BAND_LOW:   begin lo = 5552; hi = 5978; end
        BAND_MID:   begin lo = 5979; hi = 7345; end
        BAND_HIGH:  begin lo = 7346; hi = 8190; end
        default:    begin lo = 0;    hi = 8190; end
      endcase
      if (band == BAND_ANY) begin
        sa = SAMPLE_W'($urandom);
        sb = SAMPLE_W'($urandom);
      end else begin
        sum = $urandom_range(hi, lo);
        a = $urandom_range((sum < 4095) ? sum : 4095, (sum > 4095) ? sum - 4095 : 0);
        sa = SAMPLE_W'(a);
        sb = SAMPLE_W'(sum - a);
      end
      send_tick(make_item(sa, sb, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                          $urandom_range(1, 0) ? 3'b000 : 3'($urandom)));
    end
  endtask

  function automatic band_e pick_band(input mix_e mode);
    int unsigned r;
    r = $urandom_range(9, 0);
    case (mode)
      MIX_LOW:  return (r < 5) ? BAND_LOW : (r < 8) ? BAND_EMPTY : (r < 9) ? BAND_MID : BAND_ANY;
      MIX_OVER: return (r < 4) ? BAND_HIGH : (r < 7) ? BAND_MID : (r < 9) ? BAND_ANY : BAND_ZERO;
      default:  return (r < 2) ? BAND_EMPTY : (r < 4) ? BAND_LOW : (r < 6) ? BAND_MID :
                       (r < 8) ? BAND_HIGH : BAND_ANY;
    endcase
  endfunction

  // runs of steady battery level with random content, broken up by noise ticks
  task automatic run_mix(input int total, input mix_e mode);
    int    sent;
    int    len;
    band_e band;
    sent = 0;
    while (sent < total) begin
      band = pick_band(mode);
      if (band == BAND_ANY || band == BAND_ZERO) len = $urandom_range(3, 1);
      else if (mode == MIX_LOW) len = $urandom_range(100, 5);
      else len = $urandom_range(40, 5);
      if (len > total - sent) len = total - sent;
      send_eager = ($urandom_range(3, 0) == 0);
      drain_eager = ($urandom_range(3, 0) == 0);
      send_band(band, len);
      sent += len;
    end
  endtask

  task automatic idle_wait();
    push <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_EMERG_LEVEL:   cfg_shadow.emerg_level_mv = value[MV_W-1:0];
      REG_CHARGER_LEVEL: cfg_shadow.charger_level_mv = value[CHG_MV_W-1:0];
      REG_WARN_PERCENT:  cfg_shadow.warn_percent = value[PERC_W-1:0];
      REG_SHUT_PERCENT:  cfg_shadow.shutdown_percent = value[PERC_W-1:0];
      REG_DEBOUNCE:      cfg_shadow.debounce_ticks = value[15:0];
      REG_REREACTION:    cfg_shadow.rereaction_ticks = value[15:0];
      REG_MOTION_EN:     cfg_shadow.motion_led_enable = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic read_reg(input logic [2:0] idx, input string name);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'({idx, 2'b00});
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field(name, reg_value(idx), prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all_regs();
    read_reg(REG_EMERG_LEVEL, "emerg_level_mv");
    read_reg(REG_CHARGER_LEVEL, "charger_level_mv");
    read_reg(REG_WARN_PERCENT, "warn_percent");
    read_reg(REG_SHUT_PERCENT, "shutdown_percent");
    read_reg(REG_DEBOUNCE, "debounce_ticks");
    read_reg(REG_REREACTION, "rereaction_ticks");
    read_reg(REG_MOTION_EN, "motion_led_enable");
  endtask

  task automatic apply_settings(input int unsigned emerg, chg, warn, shut, deb, rerea,
                                input int unsigned motion);
    write_reg(REG_EMERG_LEVEL, emerg);
    write_reg(REG_CHARGER_LEVEL, chg);
    write_reg(REG_WARN_PERCENT, warn);
    write_reg(REG_SHUT_PERCENT, shut);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_REREACTION, rerea);
    write_reg(REG_MOTION_EN, motion);
  endtask

  task automatic test_register_access();
    read_all_regs();
    apply_settings($urandom_range(24000, 0), $urandom_range(32947, 0),
                   $urandom_range(127, 0), $urandom_range(127, 0),
                   $urandom_range(65535, 0), $urandom_range(65535, 0),
                   $urandom_range(1, 0));
    // a write outside the register map must leave everything alone
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    read_all_regs();
  endtask

  task automatic test_directed_corners();
    // debounce of zero lets warn and shutdown act on the first low tick
    apply_settings(24000, 20000, 30, 5, 0, 30000, 1);
    send_eager = 1'b0;
    drain_eager = 1'b1;
    send_tick(make_item(0, 0, 0, 0, 3'b000));
    send_tick(make_item(4095, 4095, 4095, 4095, 3'b111));
    send_tick(make_item(4095, 0, 0, 4095, 3'b100));
    send_tick(make_item(0, 4095, 4095, 0, 3'b011));
    // percent and charger thresholds, one either side
    send_tick(make_item(2733, 2733, 2485, 2486, 3'b010));
    send_tick(make_item(2733, 2734, 2486, 2486, 3'b001));
    send_tick(make_item(2742, 2742, 2485, 2486, 3'b110));
    send_tick(make_item(3817, 3818, 2486, 2486, 3'b101));
    send_tick(make_item(3818, 3818, 2485, 2486, 3'b000));
    send_tick(make_item(4095, 4095, 0, 0, 3'b000));
    for (int k = 0; k < 8; k++) send_tick(make_item(3250, 3250, 1000, 1000, 3'(k)));
    send_tick(make_item(12'hAAA, 12'h555, 12'h555, 12'hAAA, 3'b101));
    send_tick(make_item(12'h555, 12'hAAA, 12'hAAA, 12'h555, 3'b010));
    send_tick(make_item(0, 0, 2000, 2000, 3'b111));
    send_tick(make_item(2800, 2800, 2000, 2000, 3'b110));
    send_tick(make_item(3000, 3000, 2000, 2000, 3'b001));
    idle_wait();
  endtask

  task automatic test_low_battery();
    // long low stretches so the triple blink runs through its switching points
    apply_settings(24000, 0, 30, 5, 3, 30000, 1);
    run_mix(440, MIX_LOW);
    idle_wait();
  endtask

  task automatic test_motion_lights();
    apply_settings(24000, 32947, 127, 127, 65535, 30000, 0);
    run_mix(40, MIX_EVEN);
    idle_wait();
    write_reg(REG_MOTION_EN, 1);
    run_mix(80, MIX_EVEN);
    idle_wait();
  endtask

  task automatic test_backpressure();
    apply_settings(24000, 20000, 0, 0, 10, 0, 1);
    send_eager = 1'b1;
    drain_hold_cycles = 80;
    send_band(BAND_ANY, 30);
    idle_wait();
    send_eager = 1'b0;
  endtask

  task automatic test_random_mix();
    for (int pass = 0; pass < 2; pass++) begin
      apply_settings(24000, $urandom_range(32947, 0), $urandom_range(60, 20),
                     $urandom_range(15, 0), $urandom_range(20, 0), 30000, 1);
      run_mix(200, MIX_EVEN);
      idle_wait();
    end
  endtask

  // the latch only clears on reset, so this runs last
  task automatic test_emergency();
    apply_settings(0, 20000, 30, 5, 5, 4, 1);
    send_eager = 1'b0;
    drain_eager = 1'b0;
    send_band(BAND_HIGH, 3);
    send_band(BAND_ZERO, 1);
    send_band(BAND_HIGH, 4);
    send_band(BAND_ZERO, 1);
    send_band(BAND_HIGH, 12);
    send_band(BAND_ANY, 30);
    idle_wait();
    apply_settings(21500, $urandom_range(32947, 0), 127, 127, 0, 0, 1);
    run_mix(70, MIX_OVER);
    idle_wait();
    apply_settings(21500, 20000, 30, 5, 500, 65535, 0);
    run_mix(80, MIX_OVER);
    idle_wait();
  endtask

  initial begin : run_sequence
    cfg_shadow = CFG_RESET;
    pattern_phase = '0;
    over_run = '0;
    warn_run = '0;
    shut_run = '0;
    repeat_run = '0;
    emerg_latched = 1'b0;
    low_warn = 1'b0;
    lamps = 3'b000;
    push <= 1'b0;
    in_item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_register_access();
    test_directed_corners();
    test_low_battery();
    test_motion_lights();
    test_backpressure();
    test_random_mix();
    test_emergency();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
